// ===== src/q2e_pkg.sv =====
//------------------------------------------------------------------------------
// q2e_pkg
// Shared widths, codes and the CORDIC arctangent table for the quaternion to
// Euler angle converter.
//------------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 24;

    localparam int W_STATUS = 2;
    localparam int W_Q      = 32;   // input components, Q30
    localparam int W_S      = 33;   // squares, Q30
    localparam int W_T      = 36;   // atan2 operands, Q30
    localparam int W_ROOT   = 31;   // square root result, Q30
    localparam int W_XY     = 40;   // CORDIC x/y datapath
    localparam int W_Z      = 42;   // CORDIC angle, degrees Q32
    localparam int W_ROLL   = 25;
    localparam int W_PITCH  = 24;
    localparam int W_YAW    = 25;
    localparam int W_CODE   = 2;
    localparam int STEP_W   = 5;    // up to 32 CORDIC steps
    localparam int TAB_N    = 32;

    localparam longint DEG_PER_RAD_Q32 = 64'sd246083499208;
    localparam longint DEG45_Q32       = 64'sd45 <<< 32;
    localparam longint DEG90_Q32       = 64'sd90 <<< 32;

    typedef enum logic [W_CODE-1:0] {
        RC_UPDATED   = 2'd0,
        RC_WRONG_TYP = 2'd1,
        RC_BAD_FRAME = 2'd2,
        RC_NO_DATA   = 2'd3
    } t_code;

    typedef enum logic [W_STATUS-1:0] {
        FS_OK      = 2'd0,
        FS_OK_MORE = 2'd1,
        FS_EMPTY   = 2'd2,
        FS_ERROR   = 2'd3
    } t_fifo_status;

    typedef logic signed [W_Z-1:0] t_atan_tab [TAB_N];

    // one series term: (180/pi >> sh) / (2k+1)
    function automatic longint atan_term(input int k, input int sh);
        longint c;
        c = DEG_PER_RAD_Q32 >>> sh;
        case (k)
            0:  return c;
            1:  return c / 3;
            2:  return c / 5;
            3:  return c / 7;
            4:  return c / 9;
            5:  return c / 11;
            6:  return c / 13;
            7:  return c / 15;
            8:  return c / 17;
            9:  return c / 19;
            10: return c / 21;
            11: return c / 23;
            12: return c / 25;
            13: return c / 27;
            14: return c / 29;
            15: return c / 31;
            16: return c / 33;
            17: return c / 35;
            18: return c / 37;
            19: return c / 39;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic t_atan_tab build_atan_tab();
        t_atan_tab tab;
        longint    acc;
        tab[0] = W_Z'(DEG45_Q32);
        for (int i = 1; i < TAB_N; i++) begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) < 40; k++) begin
                if (k % 2 == 1) begin
                    acc = acc - atan_term(k, i * (2 * k + 1));
                end else begin
                    acc = acc + atan_term(k, i * (2 * k + 1));
                end
            end
            tab[i] = W_Z'(acc);
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan_tab();

endpackage

`default_nettype wire

// ===== src/q2e_if.sv =====
//------------------------------------------------------------------------------
// q2e_in_if / q2e_out_if
// Valid/ready channels carrying quaternion requests and angle results.
//------------------------------------------------------------------------------
`default_nettype none

interface q2e_in_if import q2e_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [W_STATUS-1:0]     fifo_status;
    logic                    quat6_present;
    logic signed [W_Q-1:0]   quat_x;
    logic signed [W_Q-1:0]   quat_y;
    logic signed [W_Q-1:0]   quat_z;

    modport source (output valid, fifo_status, quat6_present, quat_x, quat_y, quat_z,
                    input ready);
    modport sink   (input valid, fifo_status, quat6_present, quat_x, quat_y, quat_z,
                    output ready);
endinterface

interface q2e_out_if import q2e_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [W_CODE-1:0]         result_code;
    logic signed [W_ROLL-1:0]  roll_deg;
    logic signed [W_PITCH-1:0] pitch_deg;
    logic signed [W_YAW-1:0]   yaw_deg;

    modport source (output valid, result_code, roll_deg, pitch_deg, yaw_deg,
                    input ready);
    modport sink   (input valid, result_code, roll_deg, pitch_deg, yaw_deg,
                    output ready);
endinterface

`default_nettype wire

// ===== src/quaternion_to_euler_angles.sv =====
//------------------------------------------------------------------------------
// quaternion_to_euler_angles
// Rebuilds q0 from a Q30 six-axis quaternion and converts it to roll, pitch
// and yaw in degrees, holding the last good angles.
//------------------------------------------------------------------------------
// A request with a good status and the quaternion flag set is converted:
// one shared 33x33 multiplier forms the squares and then the cross products,
// one radix-4 square root unit runs twice, and one CORDIC unit runs once per
// angle. Any other request is answered from the idle state with the held
// angles. The input is not ready while a conversion runs or while a result
// waits.
`default_nettype none

module quaternion_to_euler_angles import q2e_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    q2e_in_if.sink     i_in,
    q2e_out_if.source  o_out
);

    localparam int SH = 32 - ANGLE_FRAC_BITS;
    localparam logic signed [W_Z-1:0] RND   = W_Z'(64'sd1 <<< (SH - 1));
    localparam logic signed [W_Z-1:0] LIM90 = W_Z'(64'sd90 <<< ANGLE_FRAC_BITS);
    localparam logic signed [W_Z-1:0] LIM180 = W_Z'(64'sd180 <<< ANGLE_FRAC_BITS);
    localparam logic signed [W_T-1:0] ONE_T = W_T'(64'sd1 <<< 30);
    localparam logic signed [63:0]    ONE_64 = 64'sd1 <<< 30;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL1, ST_SQ1, ST_MUL2, ST_SQ2, ST_CORD, ST_DONE
    } t_state;

    typedef enum logic [1:0] { AX_ROLL, AX_PITCH, AX_YAW } t_axis;

    t_state r_state;
    t_axis  r_sel;
    logic [2:0] r_step;

    logic signed [W_Q-1:0]   r_q1, r_q2, r_q3;
    logic [W_S-1:0]          r_s1, r_s2, r_s3;
    logic [W_ROOT-1:0]       r_q0, r_c2;
    logic signed [W_T-1:0]   r_t0, r_t2, r_t3;
    logic signed [63:0]      r_acc, r_prod;
    logic signed [W_ROLL-1:0]  r_roll, r_yaw;
    logic signed [W_PITCH-1:0] r_pitch;

    logic                      r_ov;
    logic [W_CODE-1:0]         r_o_code;
    logic signed [W_ROLL-1:0]  r_o_roll, r_o_yaw;
    logic signed [W_PITCH-1:0] r_o_pitch;

    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     mul_full;
    logic [W_S-1:0]         prod_sq;
    logic [W_S+1:0]         s_sum;
    logic signed [W_T-1:0]  rad1, rad2, t1, t4;
    logic signed [63:0]     t2_raw;
    logic                   sq_start, sq_done, cord_start, cord_done, slot_free;
    logic                   ov_set;
    logic [W_ROOT-1:0]      sq_rad, sq_root;
    logic signed [W_T-1:0]  cord_y, cord_x;
    logic signed [W_Z-1:0]  cord_z, ang_rnd, ang;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_MUL1) begin
            unique case (r_step)
                3'd0:    begin mul_a = 33'(r_q1); mul_b = 33'(r_q1); end
                3'd1:    begin mul_a = 33'(r_q2); mul_b = 33'(r_q2); end
                3'd2:    begin mul_a = 33'(r_q3); mul_b = 33'(r_q3); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == ST_MUL2) begin
            unique case (r_step)
                3'd0:    begin mul_a = $signed({2'b00, r_q0}); mul_b = 33'(r_q1); end
                3'd1:    begin mul_a = 33'(r_q2); mul_b = 33'(r_q3); end
                3'd2:    begin mul_a = $signed({2'b00, r_q0}); mul_b = 33'(r_q2); end
                3'd3:    begin mul_a = 33'(r_q3); mul_b = 33'(r_q1); end
                3'd4:    begin mul_a = $signed({2'b00, r_q0}); mul_b = 33'(r_q3); end
                3'd5:    begin mul_a = 33'(r_q1); mul_b = 33'(r_q2); end
                3'd6:    begin mul_a = r_t2[32:0]; mul_b = r_t2[32:0]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign mul_full = mul_a * mul_b;
    assign prod_sq  = r_prod[62:30];
    assign s_sum    = {2'b00, r_s1} + {2'b00, r_s2} + {2'b00, prod_sq};
    assign rad1     = ONE_T - $signed({1'b0, s_sum});
    assign rad2     = ONE_T - $signed({3'b000, prod_sq});
    assign t1       = ONE_T - $signed({1'b0, ({2'b00, r_s1} + {2'b00, r_s2}) << 1});
    assign t4       = ONE_T - $signed({1'b0, ({2'b00, r_s2} + {2'b00, r_s3}) << 1});
    assign t2_raw   = (r_acc - r_prod) >>> 29;

    always_comb begin
        sq_start = 1'b0;
        sq_rad   = '0;
        if (r_state == ST_MUL1 && r_step == 3'd3) begin
            sq_start = 1'b1;
            sq_rad   = (rad1 < 0) ? '0 : rad1[W_ROOT-1:0];
        end else if (r_state == ST_MUL2 && r_step == 3'd7) begin
            sq_start = 1'b1;
            sq_rad   = (rad2 < 0) ? '0 : rad2[W_ROOT-1:0];
        end
    end

    always_comb begin
        cord_start = 1'b0;
        cord_y     = r_t0;
        cord_x     = t1;
        if (r_state == ST_SQ2 && sq_done) begin
            cord_start = 1'b1;
        end else if (r_state == ST_CORD && cord_done && r_sel == AX_ROLL) begin
            cord_start = 1'b1;
            cord_y     = r_t2;
            cord_x     = $signed({{(W_T-W_ROOT){1'b0}}, r_c2});
        end else if (r_state == ST_CORD && cord_done && r_sel == AX_PITCH) begin
            cord_start = 1'b1;
            cord_y     = r_t3;
            cord_x     = t4;
        end
    end

    // round half up to the output scale
    assign ang_rnd = (cord_z + RND) >>> SH;
    always_comb begin
        ang = ang_rnd;
        if (r_sel == AX_PITCH) begin
            if (ang_rnd > LIM90)       ang = LIM90;
            else if (ang_rnd < -LIM90) ang = -LIM90;
        end else begin
            if (ang_rnd > LIM180)       ang = LIM180;
            else if (ang_rnd < -LIM180) ang = -LIM180;
        end
    end

    assign slot_free   = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && slot_free;
    assign o_out.valid = r_ov;
    assign o_out.result_code = r_o_code;
    assign o_out.roll_deg    = r_o_roll;
    assign o_out.pitch_deg   = r_o_pitch;
    assign o_out.yaw_deg     = r_o_yaw;

    // a result is loaded for a held-angle answer or a finished conversion
    assign ov_set = (r_state == ST_IDLE && i_in.valid && slot_free
                     && !((i_in.fifo_status == FS_OK || i_in.fifo_status == FS_OK_MORE)
                          && i_in.quat6_present))
                 || (r_state == ST_DONE && slot_free);

    q2e_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_y     (cord_y),
        .i_x     (cord_x),
        .o_done  (cord_done),
        .o_z     (cord_z)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(mul_full[63:0]);
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= AX_ROLL;
            r_step  <= '0;
            r_ov    <= 1'b0;
            r_roll  <= '0;
            r_pitch <= '0;
            r_yaw   <= '0;
        end else begin
            r_ov <= ov_set || (r_ov && !o_out.ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && slot_free) begin
                        if ((i_in.fifo_status == FS_OK || i_in.fifo_status == FS_OK_MORE)
                            && i_in.quat6_present) begin
                            r_q1    <= i_in.quat_x;
                            r_q2    <= i_in.quat_y;
                            r_q3    <= i_in.quat_z;
                            r_step  <= '0;
                            r_state <= ST_MUL1;
                        end else begin
                            r_o_roll  <= r_roll;
                            r_o_pitch <= r_pitch;
                            r_o_yaw   <= r_yaw;
                            if (i_in.fifo_status == FS_EMPTY)      r_o_code <= RC_NO_DATA;
                            else if (i_in.fifo_status == FS_ERROR) r_o_code <= RC_BAD_FRAME;
                            else                                   r_o_code <= RC_WRONG_TYP;
                        end
                    end
                end
                ST_MUL1: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1) r_s1 <= prod_sq;
                    if (r_step == 3'd2) r_s2 <= prod_sq;
                    if (r_step == 3'd3) begin
                        r_s3    <= prod_sq;
                        r_state <= ST_SQ1;
                    end
                end
                ST_SQ1: begin
                    if (sq_done) begin
                        r_q0    <= sq_root;
                        r_step  <= '0;
                        r_state <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1 || r_step == 3'd3 || r_step == 3'd5) r_acc <= r_prod;
                    if (r_step == 3'd2) r_t0 <= W_T'((r_acc + r_prod) >>> 29);
                    if (r_step == 3'd4) begin
                        if (t2_raw > ONE_64)       r_t2 <= ONE_T;
                        else if (t2_raw < -ONE_64) r_t2 <= -ONE_T;
                        else                       r_t2 <= W_T'(t2_raw);
                    end
                    if (r_step == 3'd6) r_t3 <= W_T'((r_acc + r_prod) >>> 29);
                    if (r_step == 3'd7) r_state <= ST_SQ2;
                end
                ST_SQ2: begin
                    if (sq_done) begin
                        r_c2    <= sq_root;
                        r_sel   <= AX_ROLL;
                        r_state <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (cord_done) begin
                        unique case (r_sel)
                            AX_ROLL: begin
                                r_roll <= W_ROLL'(ang);
                                r_sel  <= AX_PITCH;
                            end
                            AX_PITCH: begin
                                r_pitch <= W_PITCH'(ang);
                                r_sel   <= AX_YAW;
                            end
                            default: begin
                                r_yaw   <= W_YAW'(ang);
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_o_code  <= RC_UPDATED;
                        r_o_roll  <= r_roll;
                        r_o_pitch <= r_pitch;
                        r_o_yaw   <= r_yaw;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_sq_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_SQ1 || r_state == ST_SQ2))
        else $error("square root finished outside a root phase");

    a_cord_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == ST_CORD))
        else $error("CORDIC finished outside the angle phase");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_MUL1 || r_ov))
        else $error("accepted request neither started nor answered");

endmodule

`default_nettype wire

// ===== src/q2e_isqrt.sv =====
//------------------------------------------------------------------------------
// q2e_isqrt
// Iterative floor square root of a Q30 radicand shifted to Q60, two radicand
// bits per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module q2e_isqrt import q2e_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W_ROOT-1:0] i_rad,
    output logic                   o_done,
    output logic [W_ROOT-1:0]      o_root
);

    logic [63:0]       r_v, r_res, r_bit;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [63:0]       trial;

    assign trial  = r_res + r_bit;
    assign o_done = r_done;
    assign o_root = r_res[W_ROOT-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= {3'b000, i_rad, 30'd0};
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/q2e_cordic.sv =====
//------------------------------------------------------------------------------
// q2e_cordic
// Vectoring CORDIC atan2(y, x), one micro-rotation per cycle, angle in
// degrees Q32.
//------------------------------------------------------------------------------
`default_nettype none

module q2e_cordic import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [W_T-1:0] i_y,
    input  wire logic signed [W_T-1:0] i_x,
    output logic                      o_done,
    output logic signed [W_Z-1:0]     o_z
);

    localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

    logic signed [W_XY-1:0] r_x, r_y, dx, dy, ex, ey;
    logic signed [W_Z-1:0]  r_z;
    logic [STEP_W-1:0]      r_i;
    logic                   r_busy, r_done;

    assign ex = W_XY'(i_x);
    assign ey = W_XY'(i_y);
    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign o_done = r_done;
    assign o_z    = r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (ex == 0 && ey == 0) begin
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    // fold the left half plane by +-90 degrees
                    if (ex < 0 && ey >= 0) begin
                        r_x <= ey;
                        r_y <= -ex;
                        r_z <= W_Z'(DEG90_Q32);
                    end else if (ex < 0) begin
                        r_x <= -ey;
                        r_y <= ex;
                        r_z <= -W_Z'(DEG90_Q32);
                    end else begin
                        r_x <= ex;
                        r_y <= ey;
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ATAN_TAB[r_i];
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ATAN_TAB[r_i];
                end
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
